### rtl/xcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xcrc_pkg;

  // Frame geometry: SOH, sequence, complement, payload, CRC high, CRC low.
  localparam int PAYLOAD_BYTES = 128;
  localparam int FRAME_LAST    = PAYLOAD_BYTES + 4;
  localparam int CNT_W         = $clog2(FRAME_LAST + 1);

  localparam logic [CNT_W-1:0] CNT_SEQ    = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CMPL   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_CRC_HI = CNT_W'(PAYLOAD_BYTES + 3);

  // Input actions.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Completion status.
  localparam logic [1:0] DONE_NONE = 2'd0;
  localparam logic [1:0] DONE_OK   = 2'd1;
  localparam logic [1:0] DONE_FAIL = 2'd2;

  // Line characters.
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // Register map.
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_RETRIES = 1'b1;

  localparam logic [15:0] TIMEOUT_RST = 16'd2;
  localparam logic [3:0]  RETRIES_RST = 4'd5;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [3:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic [1:0] done_status;
  } res_t;

  // CRC-16/XMODEM, one byte at a time, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/xcrc_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module xcrc_regs
  import xcrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TIMEOUT: cfg_d.timeout_ticks = pwdata[15:0];
        REG_RETRIES: cfg_d.max_retries   = pwdata[3:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TIMEOUT_RST;
      cfg_q.max_retries   <= RETRIES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TIMEOUT: prdata = {16'h0000, cfg_q.timeout_ticks};
      REG_RETRIES: prdata = {28'h0000000, cfg_q.max_retries};
      default:     prdata = 32'h0000_0000;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/xcrc_frame.sv
`timescale 1ns / 1ps
`default_nettype none

module xcrc_frame
  import xcrc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] data_byte_i,
  input  wire cfg_t       cfg_i,
  output res_t            res_o
);

  logic             active_q, active_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       exp_seq_q, exp_seq_d;
  logic [7:0]       seq_q, seq_d;
  logic             hdr_ok_q, hdr_ok_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_hi_q, crc_hi_d;
  logic [15:0]      tick_q, tick_d;
  logic [3:0]       retry_q, retry_d;
  logic [15:0]      tick_inc;

  always_comb begin
    active_d  = active_q;
    cnt_d     = cnt_q;
    exp_seq_d = exp_seq_q;
    seq_d     = seq_q;
    hdr_ok_d  = hdr_ok_q;
    crc_d     = crc_q;
    crc_hi_d  = crc_hi_q;
    tick_d    = tick_q;
    retry_d   = retry_q;
    res_o     = '0;
    tick_inc  = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;

    if (action_i == ACT_START) begin
      active_d  = 1'b1;
      cnt_d     = '0;
      exp_seq_d = 8'd1;
      seq_d     = 8'd0;
      hdr_ok_d  = 1'b0;
      crc_d     = 16'h0000;
      crc_hi_d  = 8'd0;
      tick_d    = 16'd0;
      retry_d   = 4'd0;
      res_o.reply_valid = 1'b1;
      res_o.reply_byte  = CH_C;
    end else if (action_i == ACT_BYTE && active_q) begin
      if (cnt_q == '0) begin
        if (data_byte_i == CH_SOH) begin
          cnt_d    = CNT_SEQ;
          crc_d    = 16'h0000;
          hdr_ok_d = 1'b0;
        end else if (data_byte_i == CH_EOT) begin
          res_o.reply_valid = 1'b1;
          res_o.reply_byte  = CH_ACK;
          res_o.done_status = DONE_OK;
          active_d          = 1'b0;
        end else begin
          res_o.reply_valid = 1'b1;
          res_o.reply_byte  = CH_NAK;
        end
      end else if (cnt_q == CNT_SEQ) begin
        seq_d = data_byte_i;
        cnt_d = CNT_CMPL;
      end else if (cnt_q == CNT_CMPL) begin
        hdr_ok_d = (data_byte_i == ~seq_q) && (seq_q == exp_seq_q);
        cnt_d    = cnt_q + CNT_W'(1);
      end else if (cnt_q < CNT_CRC_HI) begin
        crc_d = crc_byte(crc_q, data_byte_i);
        cnt_d = cnt_q + CNT_W'(1);
      end else if (cnt_q == CNT_CRC_HI) begin
        crc_hi_d = data_byte_i;
        cnt_d    = cnt_q + CNT_W'(1);
      end else begin
        res_o.reply_valid = 1'b1;
        if (hdr_ok_q && ({crc_hi_q, data_byte_i} == crc_q)) begin
          res_o.reply_byte = CH_ACK;
          exp_seq_d        = exp_seq_q + 8'd1;
        end else begin
          res_o.reply_byte = CH_NAK;
        end
        cnt_d = '0;
      end
    end else if (action_i == ACT_TICK && active_q) begin
      tick_d = tick_inc;
      if (tick_inc >= cfg_i.timeout_ticks) begin
        res_o.reply_valid = 1'b1;
        res_o.reply_byte  = CH_C;
        tick_d            = 16'd0;
        if (retry_q != 4'hF) begin
          retry_d = retry_q + 4'd1;
        end
        if (retry_q >= cfg_i.max_retries) begin
          res_o.done_status = DONE_FAIL;
          active_d          = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cnt_q     <= '0;
      exp_seq_q <= 8'd1;
      seq_q     <= 8'd0;
      hdr_ok_q  <= 1'b0;
      crc_q     <= 16'h0000;
      crc_hi_q  <= 8'd0;
      tick_q    <= 16'd0;
      retry_q   <= 4'd0;
    end else if (en_i) begin
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      exp_seq_q <= exp_seq_d;
      seq_q     <= seq_d;
      hdr_ok_q  <= hdr_ok_d;
      crc_q     <= crc_d;
      crc_hi_q  <= crc_hi_d;
      tick_q    <= tick_d;
      retry_q   <= retry_d;
    end
  end

endmodule

`default_nettype wire

### rtl/xmodem_crc_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake               | Payload
// ----------+-------------------------+-------------------------------------------
// input     | in_valid_i / in_ready_o | action_i, data_byte_i
// output    | out_valid_o/ out_ready_i| reply_valid_o, reply_byte_o, done_status_o
// config    | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
//
// Each accepted transfer lands in an input register and is then processed by the framing
// logic (including a byte-wide CRC update) once the result register is free or being drained.
// The result register is loaded at the same edge as the framing state, and out_valid_o with it.
// One transfer per cycle is sustained while the output is not stalled; the framing step is combinational.
// Reset clears the session state and loads the register defaults (timeout 2, retries 5).
// A stall on the output holds the result register and the input register in the same cycle;
// in_ready_o then stays high only while the input register is empty.

module xmodem_crc_receiver_core
  import xcrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             reply_valid_o,
  output logic [7:0]       reply_byte_o,
  output logic [1:0]       done_status_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;
  logic       out_vld_q;
  logic       in_vld_q;
  logic [1:0] action_q;
  logic [7:0] data_q;
  logic       advance;

  // The processing stage moves whenever it holds a transfer and the result register is free or being drained.
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;

  xcrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  xcrc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .action_i    (action_q),
    .data_byte_i (data_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      data_q   <= data_byte_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign reply_valid_o = res_q.reply_valid;
  assign reply_byte_o  = res_q.reply_byte;
  assign done_status_o = res_q.done_status;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the XMODEM-CRC receiver core.
//
// Every input transfer causes exactly one reply transfer, so the bench keeps a
// simple in-order queue of expected replies. The expected value of each reply
// is worked out by a behavioural model of the receiver held in the scoreboard
// class. That model is fed at the clock edge at which the input transfer is
// accepted, and each reply transfer is compared with the oldest entry.
module testbench;
  import xcrc_pkg::*;

  // Kinds of frame that the stimulus can build.
  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_CMPL,
    FR_BAD_SEQ,
    FR_CUT
  } frame_kind_e;

  // The scoreboard holds its own copy of the session state and of the two
  // configuration registers, and predicts the reply to each accepted input.
  class reply_scoreboard;
    res_t        replies_due[$];
    int          errors;
    int          live_items;
    logic [15:0] cfg_timeout;
    logic [3:0]  cfg_retries;
    logic        active;
    int          frame_pos;
    logic [7:0]  next_seq;
    logic [7:0]  seq_seen;
    logic        header_good;
    logic [15:0] crc_acc;
    logic [7:0]  crc_hi;
    logic [15:0] ticks;
    logic [3:0]  retries;

    function new();
      errors      = 0;
      live_items  = 0;
      cfg_timeout = TIMEOUT_RST;
      cfg_retries = RETRIES_RST;
      open_session(1'b0);
    endfunction

    function void open_session(input logic go);
      active      = go;
      frame_pos   = 0;
      next_seq    = 8'd1;
      seq_seen    = 8'd0;
      header_good = 1'b0;
      crc_acc     = 16'd0;
      crc_hi      = 8'd0;
      ticks       = 16'd0;
      retries     = 4'd0;
    endfunction

    // Bit-serial form of the CRC-16 used on the line, data MSB first.
    static function logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function res_t predict_reply(input logic [1:0] act, input logic [7:0] b);
      res_t        r;
      logic [15:0] rx;
      logic        over;
      r = '0;
      if (act == ACT_START) begin
        open_session(1'b1);
        r.reply_valid = 1'b1;
        r.reply_byte  = CH_C;
      end else if (act == ACT_BYTE && active) begin
        if (frame_pos == 0) begin
          if (b == CH_SOH) begin
            frame_pos   = 1;
            crc_acc     = 16'd0;
            header_good = 1'b0;
          end else if (b == CH_EOT) begin
            r.reply_valid = 1'b1;
            r.reply_byte  = CH_ACK;
            r.done_status = DONE_OK;
            active        = 1'b0;
          end else begin
            r.reply_valid = 1'b1;
            r.reply_byte  = CH_NAK;
          end
        end else if (frame_pos == 1) begin
          seq_seen  = b;
          frame_pos = 2;
        end else if (frame_pos == 2) begin
          header_good = (b == ~seq_seen) && (seq_seen == next_seq);
          frame_pos   = 3;
        end else if (frame_pos < PAYLOAD_BYTES + 3) begin
          crc_acc   = crc16_next(crc_acc, b);
          frame_pos = frame_pos + 1;
        end else if (frame_pos == PAYLOAD_BYTES + 3) begin
          crc_hi    = b;
          frame_pos = frame_pos + 1;
        end else begin
          rx            = {crc_hi, b};
          r.reply_valid = 1'b1;
          if (header_good && rx == crc_acc) begin
            r.reply_byte = CH_ACK;
            next_seq     = next_seq + 8'd1;
          end else begin
            r.reply_byte = CH_NAK;
          end
          frame_pos = 0;
        end
      end else if (act == ACT_TICK && active) begin
        if (ticks != 16'hFFFF) begin
          ticks = ticks + 16'd1;
        end
        if (ticks >= cfg_timeout) begin
          over          = (retries >= cfg_retries);
          r.reply_valid = 1'b1;
          r.reply_byte  = CH_C;
          ticks         = 16'd0;
          if (retries != 4'hF) begin
            retries = retries + 4'd1;
          end
          if (over) begin
            r.done_status = DONE_FAIL;
            active        = 1'b0;
          end
        end
      end
      return r;
    endfunction

    function void note_transfer(input logic [1:0] act, input logic [7:0] b);
      if (act == ACT_START || (active && (act == ACT_BYTE || act == ACT_TICK))) begin
        live_items++;
      end
      replies_due.push_back(predict_reply(act, b));
    endfunction

    function void check_reply(input logic rv, input logic [7:0] rb, input logic [1:0] ds);
      res_t want;
      if (replies_due.size() == 0) begin
        $error("reply with nothing expected: reply_valid %0d reply_byte %02h done_status %0d",
               rv, rb, ds);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (rv !== want.reply_valid) begin
        $error("reply_valid: expected %0d, actual %0d", want.reply_valid, rv);
        errors++;
      end
      if (rb !== want.reply_byte) begin
        $error("reply_byte: expected %02h, actual %02h", want.reply_byte, rb);
        errors++;
      end
      if (ds !== want.done_status) begin
        $error("done_status: expected %0d, actual %0d", want.done_status, ds);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  logic [1:0]  action     = ACT_START;
  logic [7:0]  data_byte  = 8'd0;
  logic        out_ready  = 1'b0;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = 3'd0;
  logic [31:0] pwdata     = 32'd0;

  logic        in_ready;
  logic        out_valid;
  logic        reply_valid;
  logic [7:0]  reply_byte;
  logic [1:0]  done_status;
  logic [31:0] prdata;
  logic        pready;

  // When calm is set neither side idles; hold_len asks the reply side for one
  // long stall while the sender keeps offering transfers.
  bit          calm     = 1'b0;
  int          hold_len = 0;

  reply_scoreboard sb = new();

  xmodem_crc_receiver_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .reply_valid_o (reply_valid),
    .reply_byte_o  (reply_byte),
    .done_status_o (done_status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 4 ns clock period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Both monitors sample at the rising edge, so they see the values that the
  // edge itself acts on.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      sb.note_transfer(action, data_byte);
    end
    if (rst_ni && out_valid && out_ready) begin
      sb.check_reply(reply_valid, reply_byte, done_status);
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // The reply side: ready most of the time, with random stalls and, when
  // asked, one long hold-off counted here in cycles.
  initial begin : reply_sink
    int stall;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
        out_ready <= 1'b1;
      end else if (!rst_ni) begin
        out_ready <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall = idle_len();
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns at the edge at which it is accepted. Valid is
  // left high there, so that a following item with no gap follows at once.
  task automatic send_item(input logic [1:0] act, input logic [7:0] b);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 65) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // A stray tick now and then, so that timeouts also land in mid-frame.
  task automatic maybe_tick();
    if ($urandom_range(0, 49) == 0) begin
      send_item(ACT_TICK, 8'($urandom));
    end
  endtask

  // Builds and sends one frame. The sequence number follows the receiver's
  // own expectation unless the frame is meant to carry a wrong one.
  task automatic send_frame(input frame_kind_e kind);
    logic [7:0]  seq;
    logic [7:0]  cmpl;
    logic [7:0]  b;
    logic [15:0] crc;
    int          fill;
    int          len;
    fill = $urandom_range(0, 7);
    len  = (kind == FR_CUT) ? $urandom_range(1, PAYLOAD_BYTES) : PAYLOAD_BYTES;
    crc  = 16'd0;
    maybe_tick();
    send_item(ACT_BYTE, CH_SOH);
    // By now the transfer that ended the previous frame has surely been noted.
    seq = sb.next_seq;
    if (kind == FR_BAD_SEQ) begin
      seq = seq + 8'($urandom_range(1, 255));
    end
    cmpl = ~seq;
    if (kind == FR_BAD_CMPL) begin
      cmpl = cmpl ^ 8'(1 << $urandom_range(0, 7));
    end
    send_item(ACT_BYTE, seq);
    send_item(ACT_BYTE, cmpl);
    for (int i = 0; i < len; i++) begin
      case (fill)
        0: b = 8'h00;
        1: b = 8'hFF;
        // Control characters inside the payload must be taken as plain data.
        2: b = $urandom_range(0, 1) ? CH_SOH : CH_EOT;
        default: b = 8'($urandom);
      endcase
      crc = reply_scoreboard::crc16_next(crc, b);
      maybe_tick();
      send_item(ACT_BYTE, b);
    end
    if (kind != FR_CUT) begin
      if (kind == FR_BAD_CRC) begin
        crc = crc ^ 16'(1 << $urandom_range(0, 15));
      end
      send_item(ACT_BYTE, crc[15:8]);
      send_item(ACT_BYTE, crc[7:0]);
    end
  endtask

  // One session: a start, a few frames or disturbances, then some ending.
  // No further disturbance starts once the phase has used up its budget.
  task automatic run_session(input int budget);
    int r;
    send_item(ACT_START, 8'($urandom));
    repeat ($urandom_range(1, 5)) begin
      if (sb.live_items >= budget) begin
        break;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_frame(FR_GOOD);
      end else if (r < 63) begin
        send_frame(FR_BAD_CRC);
      end else if (r < 70) begin
        send_frame(FR_BAD_CMPL);
      end else if (r < 77) begin
        send_frame(FR_BAD_SEQ);
      end else if (r < 84) begin
        send_frame(FR_CUT);
      end else if (r < 92) begin
        send_item(ACT_BYTE, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_item(ACT_TICK, 8'($urandom));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_item(ACT_BYTE, CH_EOT);
    end else if (r < 75) begin
      repeat ($urandom_range(5, 20)) send_item(ACT_TICK, 8'($urandom));
    end else if (r < 85) begin
      send_item(2'd3, 8'($urandom));
    end
    // Otherwise the session is simply left open and the next start restarts it.
    if ($urandom_range(0, 3) == 0) begin
      send_item(2'($urandom_range(1, 3)), 8'($urandom));
    end
  endtask

  // Drops valid and waits until every expected reply has come back; since
  // each transfer causes a reply, the core is then idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.replies_due.size() != 0) @(posedge clk_i);
  endtask

  // Setup cycle, access cycle; the register takes the value at the edge that
  // ends the access cycle. The upper bits carry noise that must be dropped.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_TIMEOUT) begin
      sb.cfg_timeout = value[15:0];
    end else begin
      sb.cfg_retries = value[3:0];
    end
  endtask

  initial begin : stimulus
    logic [15:0] tmo;
    logic [3:0]  rtr;
    int          budget;
    int          waited;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the register values left by reset.
    // Nothing is open yet, so a byte, a tick and the unused action are ignored.
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_TICK, 8'h00);
    send_item(2'd3, 8'h00);
    send_item(ACT_START, 8'h00);
    // Bytes that cannot open a frame are refused.
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    // Second tick reaches the reset timeout and resends 'C'.
    send_item(ACT_TICK, 8'hAA);
    send_item(ACT_TICK, 8'h55);
    // A start while a session is open restarts it from scratch.
    send_item(ACT_START, 8'hFF);
    send_item(ACT_BYTE, CH_EOT);
    send_item(ACT_START, 8'h5A);
    send_item(2'd3, 8'hFF);
    // Six timeouts: the sixth takes the retry count past its limit and fails.
    repeat (12) send_item(ACT_TICK, 8'($urandom));
    send_item(ACT_TICK, 8'h00);

    // Random part in phases, each with its own register setting. The first
    // phase uses a zero timeout, which behaves like a timeout of one tick.
    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: begin tmo = 16'd0;     rtr = 4'd0;  end
        1: begin tmo = 16'd1;     rtr = 4'd15; end
        2: begin tmo = 16'd65535; rtr = 4'd15; end
        3: begin tmo = 16'd3;     rtr = 4'd2;  end
        default: begin tmo = 16'd40; rtr = 4'd9; end
      endcase
      write_reg(REG_TIMEOUT, {16'($urandom), tmo});
      write_reg(REG_RETRIES, {28'($urandom), rtr});
      // In the long-timeout phase nobody idles, and the reply side holds off
      // for a long stretch so that the core fills up and stalls its input.
      calm = (p == 2);
      if (p == 2) begin
        hold_len = 80;
      end
      budget = sb.live_items + 95;
      while (sb.live_items < budget) begin
        run_session(budget);
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    waited = 0;
    while (sb.replies_due.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.replies_due.size() != 0) begin
      $error("%0d replies never arrived", sb.replies_due.size());
      sb.errors++;
    end
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond any correct run.
  initial begin : watchdog
    #(64'd4_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
